// ===== rtl/stable_insertion_sorter_defines.svh =====
`ifndef STABLE_INSERTION_SORTER_DEFINES_SVH
`define STABLE_INSERTION_SORTER_DEFINES_SVH

// same-cycle implication
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic shl;
    rec_t rec;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sis_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sis_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sis_pkg::KEY_W-1:0]     key;
  logic [sis_pkg::TAG_W-1:0]            tag;
  logic                                 final_item;

  modport source (output valid, key, tag, final_item, input ready);
  modport sink (input valid, key, tag, final_item, output ready);
endinterface

interface sis_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sis_pkg::KEY_W-1:0]     key_out;
  logic [sis_pkg::TAG_W-1:0]            tag_out;
  logic                                 last_out;
  logic                                 dropped;

  modport source (output valid, key_out, tag_out, last_out, dropped, input ready);
  modport sink (input valid, key_out, tag_out, last_out, dropped, output ready);
endinterface

`default_nettype wire

// ===== rtl/sis_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sis_cell (
  input  wire logic          clk,
  input  wire sis_pkg::ctl_t ctl,
  input  wire logic          occ,
  input  wire logic          left_occ,
  input  wire logic          left_gt,
  input  wire sis_pkg::rec_t left_rec,
  input  wire sis_pkg::rec_t right_rec,
  output sis_pkg::rec_t      rec,
  output logic               gt
);

  sis_pkg::rec_t rec_next;

  assign gt = occ && ($signed(rec.key) > $signed(ctl.rec.key));

  always_comb begin
    rec_next = rec;
    if (ctl.shl) begin
      rec_next = right_rec;
    end else if (ctl.ins) begin
      if (gt) begin
        rec_next = left_gt ? left_rec : ctl.rec;
      end else if (!occ && left_occ) begin
        rec_next = left_gt ? left_rec : ctl.rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

`default_nettype wire

// ===== rtl/stable_insertion_sorter.sv =====
// channel   dir  payload                                   handshake
// records   in   key[31:0] tag[15:0] final_item            valid / ready
// sorted    out  key_out[31:0] tag_out[15:0] last_out dropped  valid / ready
//
// a record is taken when valid and ready are both high; the row of cells shifts it into place
// a final record starts a drain of n words, one per cycle while ready is high
// records is held off (ready low) from the final record until the last word
// rst is synchronous and clears the fill count, overflow flag and drain state
// cell contents are not reset
`timescale 1ns / 1ps
`default_nettype none

module stable_insertion_sorter (
  input  wire logic clk,
  input  wire logic rst,
  sis_in_if.sink    records,
  sis_out_if.source sorted
);

  logic [sis_pkg::CNT_W-1:0] fill;
  logic [sis_pkg::CNT_W-1:0] fill_next;
  logic                      drop;
  logic                      drop_next;
  logic                      draining;
  logic                      draining_next;

  logic          acc;
  logic          full;
  sis_pkg::ctl_t ctl;

  sis_pkg::rec_t cell_rec [sis_pkg::CAPACITY];
  logic          cell_gt  [sis_pkg::CAPACITY];
  logic          cell_occ [sis_pkg::CAPACITY];

  assign records.ready = !draining;
  assign acc           = records.valid && records.ready;
  assign full          = (fill == sis_pkg::CNT_W'(sis_pkg::CAPACITY));

  assign ctl.ins     = acc && !full;
  assign ctl.shl     = draining && sorted.ready;
  assign ctl.rec.key = records.key;
  assign ctl.rec.tag = records.tag;

  genvar i;
  generate
    for (i = 0; i < sis_pkg::CAPACITY; i++) begin : g_cell
      assign cell_occ[i] = (sis_pkg::CNT_W'(i) < fill);
      if (i == 0) begin : g_head
        sis_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_occ  (1'b1),
          .left_gt   (1'b0),
          .left_rec  (ctl.rec),
          .right_rec (cell_rec[i+1]),
          .rec       (cell_rec[i]),
          .gt        (cell_gt[i])
        );
      end else if (i == sis_pkg::CAPACITY - 1) begin : g_tail
        sis_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_occ  (cell_occ[i-1]),
          .left_gt   (cell_gt[i-1]),
          .left_rec  (cell_rec[i-1]),
          .right_rec ('0),
          .rec       (cell_rec[i]),
          .gt        (cell_gt[i])
        );
      end else begin : g_mid
        sis_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_occ  (cell_occ[i-1]),
          .left_gt   (cell_gt[i-1]),
          .left_rec  (cell_rec[i-1]),
          .right_rec (cell_rec[i+1]),
          .rec       (cell_rec[i]),
          .gt        (cell_gt[i])
        );
      end
    end
  endgenerate

  assign sorted.valid    = draining;
  assign sorted.key_out  = cell_rec[0].key;
  assign sorted.tag_out  = cell_rec[0].tag;
  assign sorted.last_out = (fill == sis_pkg::CNT_W'(1));
  assign sorted.dropped  = drop;

  always_comb begin
    fill_next     = fill;
    drop_next     = drop;
    draining_next = draining;
    if (acc) begin
      if (full) begin
        drop_next = 1'b1;
      end else begin
        fill_next = fill + sis_pkg::CNT_W'(1);
      end
      if (records.final_item) begin
        draining_next = 1'b1;
      end
    end
    if (ctl.shl) begin
      fill_next = fill - sis_pkg::CNT_W'(1);
      if (fill == sis_pkg::CNT_W'(1)) begin
        draining_next = 1'b0;
        drop_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      drop     <= 1'b0;
      draining <= 1'b0;
    end else begin
      fill     <= fill_next;
      drop     <= drop_next;
      draining <= draining_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sis_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "stable_insertion_sorter_defines.svh"

module sis_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic final_item,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic last_out
);

  `SIS_ASSERT_NEXT(a_final_holds_input, in_valid && in_ready && final_item, !in_ready, "input taken after final word")
  `SIS_ASSERT_NOW(a_one_set_at_a_time, out_valid, !in_ready, "input open during drain")
  `SIS_ASSERT_NEXT(a_drain_continues, out_valid && out_ready && !last_out, out_valid, "drain stopped before last word")
  `SIS_ASSERT_NEXT(a_drain_ends, out_valid && out_ready && last_out, !out_valid && in_ready, "drain did not end after last word")

endmodule

bind stable_insertion_sorter sis_checker u_sis_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (records.valid),
  .in_ready   (records.ready),
  .final_item (records.final_item),
  .out_valid  (sorted.valid),
  .out_ready  (sorted.ready),
  .last_out   (sorted.last_out)
);

`default_nettype wire

// ===== verif/stable_insertion_sorter_test.sv =====
`timescale 1ns / 1ps

module stable_insertion_sorter_test;

  localparam int KEY_W       = sis_pkg::KEY_W;
  localparam int TAG_W       = sis_pkg::TAG_W;
  localparam int CAPACITY    = sis_pkg::CAPACITY;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 40;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    final_item;
  } record_word_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    last;
    logic                    dropped;
  } sorted_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sis_in_if  records_if ();
  sis_out_if sorted_if ();

  stable_insertion_sorter DUT (
    .clk     (clk),
    .rst     (rst),
    .records (records_if),
    .sorted  (sorted_if)
  );

  always #1 clk = ~clk;

  record_word_t pending_records[$];
  sorted_word_t expected_sorted[$];

  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  logic [TAG_W-1:0]        shadow_tags [CAPACITY];
  int                      shadow_fill = 0;
  logic                    shadow_overflow = 1'b0;

  int   errors = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;
  logic hold_req = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   hold_left = 0;
  logic hold_taken = 1'b0;
  int   ready_mode = 0;
  int   mode_left = 0;

  // stable insertion: a new record goes after every stored key <= its own
  function automatic void sort_into_store(record_word_t r);
    int pos;
    sorted_word_t w;
    if (shadow_fill < CAPACITY) begin
      pos = shadow_fill;
      while (pos > 0 && shadow_keys[pos-1] > r.key) begin
        shadow_keys[pos] = shadow_keys[pos-1];
        shadow_tags[pos] = shadow_tags[pos-1];
        pos--;
      end
      shadow_keys[pos] = r.key;
      shadow_tags[pos] = r.tag;
      shadow_fill++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (r.final_item) begin
      for (int i = 0; i < shadow_fill; i++) begin
        w.key     = shadow_keys[i];
        w.tag     = shadow_tags[i];
        w.last    = (i == shadow_fill - 1);
        w.dropped = shadow_overflow;
        expected_sorted.push_back(w);
      end
      shadow_fill     = 0;
      shadow_overflow = 1'b0;
    end
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    int v;
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3, 4: begin
        v = $urandom_range(0, 6);
        return v - 3;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(KEY_W-1){1'b0}}};
          1: return {1'b0, {(KEY_W-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic queue_record(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                              logic fin);
    record_word_t r;
    r.key        = key;
    r.tag        = tag;
    r.final_item = fin;
    pending_records.push_back(r);
  endtask

  task automatic queue_set(int n);
    logic [TAG_W-1:0] tag;
    for (int i = 0; i < n; i++) begin
      tag = TAG_W'($urandom);
      queue_record(pick_key(), tag, i == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_records.size() != 0 || expected_sorted.size() != 0) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      records_if.valid <= 1'b0;
    end else if (!records_if.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        records_if.valid <= 1'b0;
      end else if (pending_records.size() == 0) begin
        records_if.valid <= 1'b0;
      end else begin
        records_if.valid      <= 1'b1;
        records_if.key        <= pending_records[0].key;
        records_if.tag        <= pending_records[0].tag;
        records_if.final_item <= pending_records[0].final_item;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      sorted_if.ready <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        sorted_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(4, 40);
        end
        mode_left--;
        case (ready_mode)
          0: sorted_if.ready <= 1'b1;
          1: sorted_if.ready <= ($urandom_range(0, 3) != 0);
          default: sorted_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor, prediction and check
  always @(posedge clk) begin
    sorted_word_t want;
    record_word_t r;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= records_if.valid && records_if.ready;
      if (records_if.valid && records_if.ready) begin
        r.key        = records_if.key;
        r.tag        = records_if.tag;
        r.final_item = records_if.final_item;
        sort_into_store(r);
        void'(pending_records.pop_front());
      end
      if (sorted_if.valid && sorted_if.ready) begin
        if (expected_sorted.size() == 0) begin
          errors++;
          $display("%0t unexpected word: key %0d tag %h last %b dropped %b", $time,
                   sorted_if.key_out, sorted_if.tag_out, sorted_if.last_out,
                   sorted_if.dropped);
        end else begin
          want = expected_sorted.pop_front();
          if (sorted_if.key_out !== want.key || sorted_if.tag_out !== want.tag ||
              sorted_if.last_out !== want.last || sorted_if.dropped !== want.dropped) begin
            errors++;
            $display("%0t mismatch: expected key %0d tag %h last %b dropped %b", $time,
                     want.key, want.tag, want.last, want.dropped);
            $display("%0t            actual key %0d tag %h last %b dropped %b", $time,
                     sorted_if.key_out, sorted_if.tag_out, sorted_if.last_out,
                     sorted_if.dropped);
          end
        end
      end
      if ((records_if.valid && records_if.ready) || (sorted_if.valid && sorted_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int random_items;
    int n;
    records_if.valid      = 1'b0;
    records_if.key        = '0;
    records_if.tag        = '0;
    records_if.final_item = 1'b0;
    sorted_if.ready       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // single-record sets at the key and tag extremes
    queue_record({1'b1, {(KEY_W-1){1'b0}}}, 16'hffff, 1'b1);
    queue_record({1'b0, {(KEY_W-1){1'b1}}}, 16'h0000, 1'b1);
    // mixed extremes with repeated keys
    queue_record({1'b0, {(KEY_W-1){1'b1}}}, 16'h0001, 1'b0);
    queue_record(0, 16'h0002, 1'b0);
    queue_record(-1, 16'h0003, 1'b0);
    queue_record({1'b1, {(KEY_W-1){1'b0}}}, 16'h0004, 1'b0);
    queue_record(-1, 16'h0005, 1'b0);
    queue_record(0, 16'h0006, 1'b1);
    // equal keys keep arrival order
    queue_record(5, 16'h000a, 1'b0);
    queue_record(5, 16'h000b, 1'b0);
    queue_record(5, 16'h000c, 1'b0);
    queue_record(5, 16'h000d, 1'b1);
    // already ascending, then descending
    queue_record(-7, 16'h5555, 1'b0);
    queue_record(3, 16'haaaa, 1'b0);
    queue_record(9, 16'h1234, 1'b1);
    queue_record(40, 16'h8000, 1'b0);
    queue_record(20, 16'h7fff, 1'b0);
    queue_record(-20, 16'h00ff, 1'b0);
    queue_record(-40, 16'hff00, 1'b1);
    wait_drained();

    // receiver holds off while sets keep coming
    random_items = 0;
    hold_req = 1'b1;
    for (int s = 0; s < 4; s++) begin
      n = $urandom_range(2, 8);
      queue_set(n);
      random_items += n;
    end
    wait_drained();

    // exactly full store, then one past it so the final record is dropped
    queue_set(CAPACITY);
    queue_set(CAPACITY + 1);
    random_items += 2 * CAPACITY + 1;
    wait_drained();

    while (random_items < 150) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      queue_set(n);
      random_items += n;
    end
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && expected_sorted.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
